### rtl/pvas_pkg.sv
// Package for polar_vector_add_sub: item structs, CORDIC constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pvas_pkg;

  localparam int GUARD = 12;
  // Cartesian width: radius 16 + guard 12 + gain/sum growth, signed
  localparam int XW = 34;
  localparam logic [31:0] GAIN_SQ = 32'd1583795537;
  localparam logic [16:0] RADIUS_MAX = 17'd131071;

  typedef struct packed {
    logic        kind;
    logic [15:0] radius_a;
    logic [15:0] angle_a;
    logic [15:0] radius_b;
    logic [15:0] angle_b;
  } in_item_t;

  typedef struct packed {
    logic [16:0] radius_out;
    logic [15:0] angle_out;
  } out_item_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051D;
      5'd2: r = 32'h09FB385B;  5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;  5'd9: r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9; 5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B; 5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028; 5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002; 5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/polar_vector_add_sub.sv
// Top level: polar vector sum/difference through pipelined CORDIC.
// Depends on pvas_pkg, pvas_rot_stage.
//
// Usage: drive in (in_item_t) with start high; busy is always low, so an item
// is accepted at every edge where start is high: one item per cycle.
// Each item flows through: input register, ITERATIONS rotation stages (both
// vectors in parallel), add/sub register, quadrant fold register, ITERATIONS
// vectoring stages, a gain multiply register and an output register.
// The result sits on result for exactly one cycle with done high; the
// receiver cannot stall, so nothing ever holds the pipeline.
// Reset clears all valid bits; data registers are not reset.
// The ITERATIONS value (8..32) sets pipeline depth and accuracy.
`timescale 1ns / 1ps
`default_nettype none
module polar_vector_add_sub #(
  parameter int ITERATIONS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire pvas_pkg::in_item_t   in,
  output logic                      done,
  output pvas_pkg::out_item_t       result
);
  import pvas_pkg::*;

  localparam int LAT = 2 * ITERATIONS + 5;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAT-2:0], start};
  end
  assign busy = 1'b0;
  assign done = vld[LAT-1];

  // stage 0: quadrant fold of each input vector
  logic signed [XW-1:0] xa0, xb0;
  logic [31:0] za0, zb0;
  logic kind_d [ITERATIONS+1];

  function automatic logic [31:0] fold_z(input logic [15:0] a);
    logic [31:0] z;
    z = {a, 16'd0};
    if (((z + 32'h40000000) & 32'h80000000) != 0) z = z + 32'h80000000;
    return z;
  endfunction

  function automatic logic signed [XW-1:0] fold_x(input logic [15:0] r, input logic [15:0] a);
    logic [31:0] z;
    logic signed [XW-1:0] x;
    z = {a, 16'd0};
    x = $signed({{(XW-16-GUARD){1'b0}}, r, {GUARD{1'b0}}});
    if (((z + 32'h40000000) & 32'h80000000) != 0) x = -x;
    return x;
  endfunction

  always_ff @(posedge clk) begin
    xa0 <= fold_x(in.radius_a, in.angle_a);
    xb0 <= fold_x(in.radius_b, in.angle_b);
    za0 <= fold_z(in.angle_a);
    zb0 <= fold_z(in.angle_b);
    kind_d[0] <= in.kind;
  end

  logic signed [XW-1:0] xa [ITERATIONS+1];
  logic signed [XW-1:0] ya [ITERATIONS+1];
  logic signed [XW-1:0] xb [ITERATIONS+1];
  logic signed [XW-1:0] yb [ITERATIONS+1];
  logic [31:0] za [ITERATIONS+1];
  logic [31:0] zb [ITERATIONS+1];
  assign xa[0] = xa0;
  assign ya[0] = '0;
  assign za[0] = za0;
  assign xb[0] = xb0;
  assign yb[0] = '0;
  assign zb[0] = zb0;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
    pvas_rot_stage #(.STAGE(i), .VECTORING(1'b0)) u_a (
      .clk(clk), .x_in(xa[i]), .y_in(ya[i]), .z_in(za[i]),
      .x_out(xa[i+1]), .y_out(ya[i+1]), .z_out(za[i+1]));
    pvas_rot_stage #(.STAGE(i), .VECTORING(1'b0)) u_b (
      .clk(clk), .x_in(xb[i]), .y_in(yb[i]), .z_in(zb[i]),
      .x_out(xb[i+1]), .y_out(yb[i+1]), .z_out(zb[i+1]));
    always_ff @(posedge clk) kind_d[i+1] <= kind_d[i];
  end

  // add/sub
  logic signed [XW-1:0] xs, ys;
  always_ff @(posedge clk) begin
    xs <= kind_d[ITERATIONS] ? xa[ITERATIONS] - xb[ITERATIONS]
                             : xa[ITERATIONS] + xb[ITERATIONS];
    ys <= kind_d[ITERATIONS] ? ya[ITERATIONS] - yb[ITERATIONS]
                             : ya[ITERATIONS] + yb[ITERATIONS];
  end

  // fold into right half plane, flag zero vector
  logic signed [XW-1:0] xv [ITERATIONS+1];
  logic signed [XW-1:0] yv [ITERATIONS+1];
  logic [31:0] zv [ITERATIONS+1];
  logic zero_d [ITERATIONS+1];
  logic signed [XW-1:0] xf, yf;
  logic [31:0] zf;
  logic zf_zero;
  always_ff @(posedge clk) begin
    zf_zero <= (xs == 0) && (ys == 0);
    if (xs[XW-1]) begin
      xf <= -xs; yf <= -ys; zf <= 32'h80000000;
    end else begin
      xf <= xs; yf <= ys; zf <= '0;
    end
  end
  assign xv[0] = xf;
  assign yv[0] = yf;
  assign zv[0] = zf;
  assign zero_d[0] = zf_zero;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_vec
    pvas_rot_stage #(.STAGE(i), .VECTORING(1'b1)) u_v (
      .clk(clk), .x_in(xv[i]), .y_in(yv[i]), .z_in(zv[i]),
      .x_out(xv[i+1]), .y_out(yv[i+1]), .z_out(zv[i+1]));
    always_ff @(posedge clk) zero_d[i+1] <= zero_d[i];
  end

  // gain multiply: x is nonnegative here and fits 32 bits
  logic [63:0] prod;
  logic [31:0] zm;
  logic zm_zero;
  always_ff @(posedge clk) begin
    prod <= 64'(xv[ITERATIONS][31:0]) * 64'(GAIN_SQ);
    zm <= zv[ITERATIONS];
    zm_zero <= zero_d[ITERATIONS];
  end

  logic [63:0] rsum;
  logic [31:0] zr;
  assign rsum = (prod + (64'd1 << (31 + GUARD))) >> (32 + GUARD);
  assign zr = zm + 32'h8000;
  always_ff @(posedge clk) begin
    if (zm_zero) begin
      result.radius_out <= '0;
      result.angle_out <= '0;
    end else begin
      result.radius_out <= (rsum > 64'(RADIUS_MAX)) ? RADIUS_MAX : rsum[16:0];
      result.angle_out <= zr[31:16];
    end
  end

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) !busy) else $error("busy high");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(start, LAT) && !$past(rst, LAT) |-> done) else $error("item lost");
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    $past(zm_zero) && done |-> result.radius_out == 0 && result.angle_out == 0)
    else $error("zero vector result wrong");
`endif

endmodule
`default_nettype wire

### rtl/pvas_rot_stage.sv
// One registered CORDIC micro-rotation stage, rotation or vectoring mode.
// Depends on pvas_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pvas_rot_stage #(
  parameter int STAGE = 0,
  parameter bit VECTORING = 1'b0
) (
  input  wire logic                     clk,
  input  wire logic signed [pvas_pkg::XW-1:0] x_in,
  input  wire logic signed [pvas_pkg::XW-1:0] y_in,
  input  wire logic [31:0]              z_in,
  output logic signed [pvas_pkg::XW-1:0]      x_out,
  output logic signed [pvas_pkg::XW-1:0]      y_out,
  output logic [31:0]                   z_out
);
  import pvas_pkg::*;

  logic signed [XW-1:0] dx, dy;
  logic [31:0] at;
  logic dir_pos;
  logic sub_x;

  always_comb begin
    dx = y_in >>> STAGE;
    dy = x_in >>> STAGE;
    at = atan_lut(5'(STAGE));
    // rotation: sign of residual angle; vectoring: drive y toward zero
    dir_pos = VECTORING ? !y_in[XW-1] : !z_in[31];
    sub_x = VECTORING ? !dir_pos : dir_pos;
  end

  always_ff @(posedge clk) begin
    if (sub_x) begin
      x_out <= x_in - dx;
      y_out <= y_in + dy;
      z_out <= z_in - at;
    end else begin
      x_out <= x_in + dx;
      y_out <= y_in - dy;
      z_out <= z_in + at;
    end
  end

endmodule
`default_nettype wire
